// ----- rtl/deq_pkg.sv -----
// Shared types and constants for the double-ended priority queue.
// Used by the cell, the cell chain and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	localparam int KEY_W        = 32;
	localparam int COUNT_W      = 7;
	localparam int OP_W         = 2;
	localparam int CAPACITY_DEF = 64;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_DEL_MAX = 2'd1,
		OP_DEL_MIN = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// Command broadcast to every cell of the chain in the cycle of a transfer.
	typedef struct packed {
		logic ins;
		logic del_max;
		logic del_min;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/double_ended_priority_queue_top.sv -----
// Top level of the double-ended priority queue: handshakes, count, flags and result register.
// Depends on deq_pkg and deq_chain.
`timescale 1ns / 1ps
`default_nettype none

// The queue keeps up to CAPACITY signed keys in a row of cells sorted in ascending
// order, and takes one insert, remove-largest or remove-smallest request per clock
// while in_ready is high. Each cell compares the incoming key with its own and its
// neighbor's, so the whole row updates in the cycle of the input transfer; the request
// is then held in stage one, and the result (largest key, smallest key, count and the
// two fault flags) is registered, after the selection of the last occupied cell, when
// the result register frees up. A waiting result does not block the next input transfer
// unless a second result is also waiting. After reset the queue is empty and ready at once.
module double_ended_priority_queue_top #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [deq_pkg::OP_W-1:0]           op,
	input  logic signed [deq_pkg::KEY_W-1:0]   key_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [deq_pkg::KEY_W-1:0]   max_key,
	output logic signed [deq_pkg::KEY_W-1:0]   min_key,
	output logic [deq_pkg::COUNT_W-1:0]        entry_count,
	output logic                               full_drop,
	output logic                               empty_remove
);
	import deq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           count_d;
	logic [CNT_W+COUNT_W-1:0]   count_ext;
	logic                       accept;
	logic                       is_full;
	logic                       is_empty;
	cell_ctl_t                  ctl;
	logic                       drop_now;
	logic                       empty_now;
	logic signed [KEY_W-1:0]    head_key;
	logic signed [KEY_W-1:0]    tail_key;

	logic                       valid_s1;
	logic                       full_drop_s1;
	logic                       empty_remove_s1;
	logic                       adv_s1;

	logic                       out_valid_q;
	logic signed [KEY_W-1:0]    max_key_q;
	logic signed [KEY_W-1:0]    min_key_q;
	logic [COUNT_W-1:0]         entry_count_q;
	logic                       full_drop_q;
	logic                       empty_remove_q;

	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	// The stage-one item moves to the result register whenever that register frees up.
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ctl       = '0;
		drop_now  = 1'b0;
		empty_now = 1'b0;
		count_d   = count_q;
		if (accept) begin
			unique case (op_t'(op))
				OP_INSERT: begin
					if (is_full) begin
						drop_now = 1'b1;
					end else begin
						ctl.ins = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
				OP_DEL_MAX: begin
					if (is_empty) begin
						empty_now = 1'b1;
					end else begin
						ctl.del_max = 1'b1;
						count_d     = count_q - CNT_W'(1);
					end
				end
				OP_DEL_MIN: begin
					if (is_empty) begin
						empty_now = 1'b1;
					end else begin
						ctl.del_min = 1'b1;
						count_d     = count_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	deq_chain #(
		.CAPACITY (CAPACITY)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.ins_key  (key_in),
		.head_key (head_key),
		.tail_key (tail_key)
	);

	assign count_ext = {{COUNT_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			full_drop_s1    <= drop_now;
			empty_remove_s1 <= empty_now;
		end
		// The cells already hold the state after the stage-one item when it advances.
		if (adv_s1) begin
			max_key_q      <= tail_key;
			min_key_q      <= head_key;
			entry_count_q  <= count_ext[COUNT_W-1:0];
			full_drop_q    <= full_drop_s1;
			empty_remove_q <= empty_remove_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign max_key      = max_key_q;
	assign min_key      = min_key_q;
	assign entry_count  = entry_count_q;
	assign full_drop    = full_drop_q;
	assign empty_remove = empty_remove_q;

endmodule

`default_nettype wire

// ----- rtl/deq_cell.sv -----
// One cell of the sorted chain: holds a key and its valid bit.
// Depends on deq_pkg; instantiated by deq_chain.
`timescale 1ns / 1ps
`default_nettype none

module deq_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  deq_pkg::cell_ctl_t               ctl,
	input  logic signed [deq_pkg::KEY_W-1:0] ins_key,
	input  logic signed [deq_pkg::KEY_W-1:0] left_key,
	input  logic                             left_valid,
	input  logic                             left_gt,
	input  logic signed [deq_pkg::KEY_W-1:0] right_key,
	input  logic                             right_valid,
	output logic signed [deq_pkg::KEY_W-1:0] key,
	output logic                             valid,
	output logic                             gt,
	output logic                             last
);
	import deq_pkg::*;

	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] key_d;
	logic                    valid_q;
	logic                    valid_d;

	// An empty cell behaves as if it held a key above every possible key.
	assign gt    = !valid_q || (key_q > ins_key);
	assign key   = key_q;
	assign valid = valid_q;
	assign last  = valid_q && !right_valid;

	always_comb begin
		key_d   = key_q;
		valid_d = valid_q;
		if (ctl.ins) begin
			// Keys above the new one move up by one place; equal keys stay in front.
			if (gt) begin
				key_d = left_gt ? left_key : ins_key;
			end
			valid_d = valid_q || left_valid;
		end else if (ctl.del_min) begin
			key_d   = right_key;
			valid_d = right_valid;
		end else if (ctl.del_max) begin
			valid_d = right_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

endmodule

`default_nettype wire

// ----- rtl/deq_chain.sv -----
// Row of deq_cell instances kept in ascending key order, plus the head and tail selects.
// Depends on deq_pkg and deq_cell; instantiated by the top level.
`timescale 1ns / 1ps
`default_nettype none

module deq_chain #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  deq_pkg::cell_ctl_t               ctl,
	input  logic signed [deq_pkg::KEY_W-1:0] ins_key,
	output logic signed [deq_pkg::KEY_W-1:0] head_key,
	output logic signed [deq_pkg::KEY_W-1:0] tail_key
);
	import deq_pkg::*;

	logic signed [KEY_W-1:0] cell_key   [CAPACITY];
	logic                    cell_valid [CAPACITY];
	logic                    cell_gt    [CAPACITY];
	logic                    cell_last  [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [KEY_W-1:0] l_key;
		logic                    l_valid;
		logic                    l_gt;
		logic signed [KEY_W-1:0] r_key;
		logic                    r_valid;

		if (i == 0) begin : g_first
			assign l_key   = '0;
			assign l_valid = 1'b1;
			assign l_gt    = 1'b0;
		end else begin : g_inner_l
			assign l_key   = cell_key[i-1];
			assign l_valid = cell_valid[i-1];
			assign l_gt    = cell_gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_final
			assign r_key   = '0;
			assign r_valid = 1'b0;
		end else begin : g_inner_r
			assign r_key   = cell_key[i+1];
			assign r_valid = cell_valid[i+1];
		end

		deq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.ins_key     (ins_key),
			.left_key    (l_key),
			.left_valid  (l_valid),
			.left_gt     (l_gt),
			.right_key   (r_key),
			.right_valid (r_valid),
			.key         (cell_key[i]),
			.valid       (cell_valid[i]),
			.gt          (cell_gt[i]),
			.last        (cell_last[i])
		);
	end

	assign head_key = cell_valid[0] ? cell_key[0] : '0;

	// Exactly one cell is marked last when the store holds keys, none when it is empty.
	always_comb begin
		tail_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tail_key = tail_key | (cell_key[i] & {KEY_W{cell_last[i]}});
		end
	end

endmodule

`default_nettype wire
